@@ hdl/ole_pkg.sv @@
// ----------------------------------------------------------------------------
// ole_pkg
// Shared codes and the per-cell control word of the ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

  localparam int DW = 32;

  typedef enum logic [3:0] {
    ACT_INS_FRONT  = 4'd0,
    ACT_INS_BACK   = 4'd1,
    ACT_INS_AFTER  = 4'd2,
    ACT_INS_BEFORE = 4'd3,
    ACT_PEEK_FRONT = 4'd4,
    ACT_PEEK_BACK  = 4'd5,
    ACT_POP_FRONT  = 4'd6,
    ACT_POP_BACK   = 4'd7,
    ACT_REMOVE     = 4'd8
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXEC
  } state_t;

  // How each cell moves its entry when the control word applies
  typedef enum logic [2:0] {
    SH_HOLD,
    SH_FRONT,
    SH_BACK,
    SH_AFTER,
    SH_BEFORE,
    SH_DROP_KEY,
    SH_DROP_FRONT
  } shift_t;

  typedef struct packed {
    logic            capture;  // register key match in every cell
    logic            apply;    // perform the shift below
    shift_t          shift;
    logic [DW-1:0]   key;
    logic [DW-1:0]   value;
  } cell_ctl_t;

endpackage

@@ hdl/ordered_list_engine.sv @@
// ----------------------------------------------------------------------------
// ordered_list_engine
// Bounded ordered list of signed words held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage: one command word enters on in_* (action, find_only, key, value)
// under valid/ready and yields exactly one result word on out_* (status,
// data_out, found, length, is_empty).
// Each command passes the accept, compare and execute steps: the accept
// edge latches it, the compare step registers the key compare in every
// cell, and the execute step runs the first-match chain, shifts the cells
// and loads the output register, which raises out_valid. in_ready is high
// only in the idle step, so a new command is taken only after the last one
// has left its execute step.
// A new command is accepted while a result still waits on out_*; it then
// holds in its execute step until the output register is taken, so a
// stalled receiver blocks the list, never drops a result.
// Reset (rst_n low, synchronous) empties the list; cell contents are not
// cleared, entries past the length are never read.
// ----------------------------------------------------------------------------
module ordered_list_engine import ole_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [3:0]           in_action,
  input  logic                 in_find_only,
  input  logic signed [31:0]   in_key,
  input  logic signed [31:0]   in_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic signed [31:0]   out_data_out,
  output logic                 out_found,
  output logic [4:0]           out_length,
  output logic                 out_is_empty
);

  localparam int CW = $clog2(CAPACITY + 1);

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [3:0]    act_r;
  logic          fonly_r;
  logic [DW-1:0] key_r, val_r;
  logic [DW-1:0] back_r;
  logic          out_valid_r, out_valid_nxt;
  status_t       status_r, status_nxt;
  logic [DW-1:0] data_r, data_nxt;
  logic          found_r, found_nxt;
  logic [CW-1:0] len_r;

  cell_ctl_t     ctl;
  shift_t        shift;
  logic          exec_go;
  logic          hit;
  logic          full, empty;

  logic [DW-1:0] entry_w [CAPACITY];
  logic          hb_w    [CAPACITY+1];
  logic [DW-1:0] tail_w  [CAPACITY+1];

  assign hb_w[0]   = 1'b0;
  assign tail_w[0] = '0;
  assign hit       = hb_w[CAPACITY];

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [DW-1:0] left_d, right_d;
      logic          left_hb;
      if (gi == 0) begin : g_first
        assign left_d  = val_r;
        assign left_hb = 1'b0;
      end else begin : g_mid
        assign left_d  = entry_w[gi-1];
        assign left_hb = hb_w[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign right_d = entry_w[gi];
      end else begin : g_nlast
        assign right_d = entry_w[gi+1];
      end
      ole_cell #(.IDX(gi), .CW(CW)) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .count_i   (count_r),
        .left_i    (left_d),
        .right_i   (right_d),
        .hb_i      (hb_w[gi]),
        .left_hb_i (left_hb),
        .hb_o      (hb_w[gi+1]),
        .tail_i    (tail_w[gi]),
        .tail_o    (tail_w[gi+1]),
        .entry_o   (entry_w[gi])
      );
    end
  endgenerate

  assign full    = (count_r == CW'(CAPACITY));
  assign empty   = (count_r == '0);
  assign exec_go = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  assign ctl.capture = (state_r == S_CMP);
  assign ctl.apply   = exec_go;
  assign ctl.shift   = shift;
  assign ctl.key     = key_r;
  assign ctl.value   = val_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    shift         = SH_HOLD;
    status_nxt    = STAT_OK;
    data_nxt      = '0;
    found_nxt     = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_CMP;
      S_CMP:  state_nxt = S_EXEC;
      S_EXEC: begin
        if (exec_go) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          unique case (act_r)
            ACT_INS_FRONT, ACT_INS_BACK: begin
              if (full) status_nxt = STAT_FULL;
              else begin
                shift     = (act_r == ACT_INS_FRONT) ? SH_FRONT : SH_BACK;
                count_nxt = count_r + 1'b1;
              end
            end
            ACT_INS_AFTER, ACT_INS_BEFORE: begin
              found_nxt = hit;
              if (full)      status_nxt = STAT_FULL;
              else if (!hit) status_nxt = STAT_NOT_FOUND;
              else begin
                shift     = (act_r == ACT_INS_AFTER) ? SH_AFTER : SH_BEFORE;
                count_nxt = count_r + 1'b1;
              end
            end
            ACT_PEEK_FRONT, ACT_POP_FRONT: begin
              if (empty) status_nxt = STAT_EMPTY;
              else begin
                data_nxt = entry_w[0];
                if (act_r == ACT_POP_FRONT) begin
                  shift     = SH_DROP_FRONT;
                  count_nxt = count_r - 1'b1;
                end
              end
            end
            ACT_PEEK_BACK, ACT_POP_BACK: begin
              if (empty) status_nxt = STAT_EMPTY;
              else begin
                data_nxt = back_r;
                if (act_r == ACT_POP_BACK) count_nxt = count_r - 1'b1;
              end
            end
            ACT_REMOVE: begin
              found_nxt = hit;
              if (!hit) status_nxt = STAT_NOT_FOUND;
              else if (!fonly_r) begin
                shift     = SH_DROP_KEY;
                count_nxt = count_r - 1'b1;
              end
            end
            default: ;  // unused codes: no change
          endcase
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      act_r   <= in_action;
      fonly_r <= in_find_only;
      key_r   <= in_key;
      val_r   <= in_value;
    end
    if (state_r == S_CMP) back_r <= tail_w[CAPACITY];
    if (exec_go) begin
      status_r <= status_nxt;
      data_r   <= data_nxt;
      found_r  <= found_nxt;
      len_r    <= count_nxt;
    end
  end

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_data_out = data_r;
  assign out_found    = found_r;
  assign out_length   = 5'(len_r);
  assign out_is_empty = (len_r == '0);

endmodule

@@ hdl/ole_cell.sv @@
// ----------------------------------------------------------------------------
// ole_cell
// One list position: holds an entry, matches it against the key and takes
// its next entry from the new value or from a neighbor.
// ----------------------------------------------------------------------------
module ole_cell import ole_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic          clk,
  input  cell_ctl_t     ctl,
  input  logic [CW-1:0] count_i,
  input  logic [DW-1:0] left_i,
  input  logic [DW-1:0] right_i,
  input  logic          hb_i,       // some earlier cell matched
  input  logic          left_hb_i,  // some cell before the left one matched
  output logic          hb_o,
  input  logic [DW-1:0] tail_i,
  output logic [DW-1:0] tail_o,
  output logic [DW-1:0] entry_o
);

  logic [DW-1:0] entry_r, entry_nxt;
  logic          match_r, match_nxt;
  logic          valid;
  logic          left_first;

  assign valid      = CW'(IDX) < count_i;
  assign match_nxt  = valid && (entry_r == ctl.key);
  assign hb_o       = hb_i | match_r;
  assign left_first = hb_i & ~left_hb_i;
  assign tail_o     = tail_i | ((count_i == CW'(IDX + 1)) ? entry_r : '0);
  assign entry_o    = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.apply) begin
      unique case (ctl.shift)
        SH_FRONT:      entry_nxt = left_i;
        SH_BACK:       if (count_i == CW'(IDX)) entry_nxt = ctl.value;
        SH_AFTER: begin
          if (left_first)     entry_nxt = ctl.value;
          else if (left_hb_i) entry_nxt = left_i;
        end
        SH_BEFORE: begin
          if (match_r && !hb_i) entry_nxt = ctl.value;
          else if (hb_i)        entry_nxt = left_i;
        end
        SH_DROP_KEY:   if (hb_i || match_r) entry_nxt = right_i;
        SH_DROP_FRONT: entry_nxt = right_i;
        default:       entry_nxt = entry_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (ctl.capture) match_r <= match_nxt;
  end

endmodule

@@ sim/ordered_list_engine_checker.sv @@
// ----------------------------------------------------------------------------
// ordered_list_engine_checker
// Watches both channels of the ordered list engine, keeps its own copy of
// the list, and compares every result word against the predicted one.
// ----------------------------------------------------------------------------
module ordered_list_engine_checker import ole_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [3:0]          in_action,
  input  logic                in_find_only,
  input  logic signed [31:0]  in_key,
  input  logic signed [31:0]  in_value,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [1:0]          out_status,
  input  logic signed [31:0]  out_data_out,
  input  logic                out_found,
  input  logic [4:0]          out_length,
  input  logic                out_is_empty,
  output int                  fail_count,
  output int                  outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_t            status;
    logic signed [31:0] data;
    logic               found;
    logic [4:0]         length;
    logic               is_empty;
  } list_answer_t;

  logic signed [31:0] list_words[$];   // front at index 0
  list_answer_t       answers_due[$];
  int                 mismatches = 0;

  // Apply one command to the local list and return the answer it should give.
  function automatic list_answer_t run_command(logic [3:0] act, logic fonly,
                                               logic signed [31:0] k,
                                               logic signed [31:0] v);
    list_answer_t ans;
    int           pos;
    logic         hit;
    logic         full;
    ans.status = STAT_OK;
    ans.data   = '0;
    ans.found  = 1'b0;
    pos = list_words.size();
    // scan from the back so the first match from the front wins
    for (int i = list_words.size() - 1; i >= 0; i--)
      if (list_words[i] == k) pos = i;
    hit  = (pos < list_words.size());
    full = (list_words.size() >= CAPACITY);
    unique case (act)
      ACT_INS_FRONT, ACT_INS_BACK: begin
        if (full) ans.status = STAT_FULL;
        else if (act == ACT_INS_FRONT) list_words.push_front(v);
        else list_words.push_back(v);
      end
      ACT_INS_AFTER, ACT_INS_BEFORE: begin
        ans.found = hit;
        if (full) ans.status = STAT_FULL;
        else if (!hit) ans.status = STAT_NOT_FOUND;
        else list_words.insert((act == ACT_INS_AFTER) ? pos + 1 : pos, v);
      end
      ACT_PEEK_FRONT, ACT_PEEK_BACK, ACT_POP_FRONT, ACT_POP_BACK: begin
        if (list_words.size() == 0) begin
          ans.status = STAT_EMPTY;
        end else if (act == ACT_PEEK_FRONT) begin
          ans.data = list_words[0];
        end else if (act == ACT_PEEK_BACK) begin
          ans.data = list_words[list_words.size() - 1];
        end else if (act == ACT_POP_FRONT) begin
          ans.data = list_words.pop_front();
        end else begin
          ans.data = list_words.pop_back();
        end
      end
      ACT_REMOVE: begin
        ans.found = hit;
        if (!hit) ans.status = STAT_NOT_FOUND;
        else if (!fonly) list_words.delete(pos);
      end
      default: ;
    endcase
    ans.length   = 5'(list_words.size());
    ans.is_empty = (list_words.size() == 0);
    return ans;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    list_answer_t want;
    if (!rst_n) begin
      list_words.delete();
      answers_due.delete();
    end else begin
      if (in_valid && in_ready)
        answers_due.push_back(run_command(in_action, in_find_only, in_key, in_value));
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          $error("result word with nothing expected");
          mismatches++;
        end else begin
          want = answers_due.pop_front();
          check_field("status",   32'(want.status),   32'(out_status));
          check_field("data_out", want.data,          out_data_out);
          check_field("found",    32'(want.found),    32'(out_found));
          check_field("length",   32'(want.length),   32'(out_length));
          check_field("is_empty", 32'(want.is_empty), 32'(out_is_empty));
        end
      end
    end
    fail_count  <= mismatches;
    outstanding <= answers_due.size();
  end

endmodule

@@ sim/ordered_list_engine_test.sv @@
// ----------------------------------------------------------------------------
// ordered_list_engine_test
// Drives directed and random commands into the ordered list engine with
// bursty input and a stalling receiver; the checker predicts and compares.
// ----------------------------------------------------------------------------
module ordered_list_engine_test import ole_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CAPACITY     = 16;
  localparam int          PHASES       = 7;
  localparam int          PHASE_WORDS  = 147;
  localparam int          LONG_HOLD    = 300;
  localparam int          HOLD_AT      = 400;
  localparam int          IDLE_LIMIT   = 3000;
  localparam int          SETTLE       = 10;
  localparam logic [3:0]  ACT_FIRST_UNUSED = 4'd9;
  localparam logic [3:0]  ACT_LAST_CODE    = 4'd15;

  localparam int KIND_FILL  = 0;
  localparam int KIND_MIXED = 1;
  localparam int KIND_DRAIN = 2;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [3:0]         in_action;
  logic               in_find_only;
  logic signed [31:0] in_key;
  logic signed [31:0] in_value;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_status;
  logic signed [31:0] out_data_out;
  logic               out_found;
  logic [4:0]         out_length;
  logic               out_is_empty;
  int                 fail_count;
  int                 outstanding;

  int                 words_sent = 0;
  bit                 held_off = 0;
  logic [31:0]        word_pool [0:7];

  ordered_list_engine #(.CAPACITY(CAPACITY)) u_dut (.*);

  ordered_list_engine_checker #(.CAPACITY(CAPACITY)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Small pool so keys hit entries often; extremes cover every bit.
  function automatic logic [31:0] pick_word();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return word_pool[$urandom_range(0, 7)];
  endfunction

  function automatic logic [3:0] pick_action(int kind);
    int r;
    int ins_pct;
    r = $urandom_range(0, 99);
    ins_pct = (kind == KIND_FILL) ? 70 : (kind == KIND_MIXED) ? 45 : 20;
    if (r >= 95) return 4'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_CODE));
    if (r < ins_pct) return 4'($urandom_range(ACT_INS_FRONT, ACT_INS_BEFORE));
    return 4'($urandom_range(ACT_PEEK_FRONT, ACT_REMOVE));
  endfunction

  task automatic send_word(input logic [3:0] act, input logic fonly,
                           input logic [31:0] k, input logic [31:0] v);
    in_valid     <= 1'b1;
    in_action    <= act;
    in_find_only <= fonly;
    in_key       <= k;
    in_value     <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // Stop offering and wait until every predicted word has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Receiver: segments of always-ready, coin-flip and fixed stall pattern,
  // plus one long hold-off that backs the list up into the input.
  initial begin : receiver
    int         seg_left;
    int         mode;
    int         cyc;
    logic [7:0] pat;
    seg_left = 0;
    mode = 0;
    cyc = 0;
    pat = 8'hff;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held_off && words_sent >= HOLD_AT) begin
        held_off = 1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (seg_left == 0) begin
          mode = $urandom_range(0, 2);
          pat = 8'($urandom) | 8'h01;
          seg_left = $urandom_range(20, 200);
        end
        seg_left--;
        cyc++;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= pat[cyc % 8];
        endcase
      end
    end
  end

  // Watchdog: too long without any word moving on either side.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("ordered_list_engine_test NOT OK");
    $finish;
  end

  initial begin : stimulus
    int burst_left;
    int kind;
    word_pool[0] = 32'h8000_0000;
    word_pool[1] = 32'h7fff_ffff;
    word_pool[2] = 32'h0000_0000;
    word_pool[3] = 32'hffff_ffff;
    word_pool[4] = 32'h0000_0001;
    word_pool[5] = 32'h5555_5555;
    word_pool[6] = 32'haaaa_aaaa;
    word_pool[7] = $urandom;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_action    <= ACT_INS_FRONT;
    in_find_only <= 1'b0;
    in_key       <= '0;
    in_value     <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty list: every read and search fails
    send_word(ACT_PEEK_FRONT, 1'b0, 32'h0, 32'h0);
    send_word(ACT_PEEK_BACK,  1'b0, 32'h0, 32'h0);
    send_word(ACT_POP_FRONT,  1'b0, 32'h0, 32'h0);
    send_word(ACT_POP_BACK,   1'b0, 32'h0, 32'h0);
    send_word(ACT_REMOVE,     1'b0, 32'h0, 32'h0);
    send_word(ACT_REMOVE,     1'b1, 32'h0, 32'h0);
    send_word(ACT_INS_AFTER,  1'b0, 32'h5, 32'h7);
    send_word(ACT_INS_BEFORE, 1'b0, 32'h5, 32'h7);
    // extremes, insert around keys, duplicates
    send_word(ACT_INS_FRONT,  1'b1, 32'h0, 32'h8000_0000);
    send_word(ACT_INS_BACK,   1'b0, 32'h0, 32'h7fff_ffff);
    send_word(ACT_INS_AFTER,  1'b0, 32'h8000_0000, 32'hffff_ffff);
    send_word(ACT_INS_BEFORE, 1'b1, 32'h7fff_ffff, 32'h0);
    send_word(ACT_INS_FRONT,  1'b0, 32'h0, 32'h7fff_ffff);
    send_word(ACT_REMOVE,     1'b1, 32'h7fff_ffff, 32'h0);
    send_word(ACT_REMOVE,     1'b0, 32'h7fff_ffff, 32'h0);
    send_word(ACT_PEEK_FRONT, 1'b1, 32'h0, 32'h0);
    send_word(ACT_PEEK_BACK,  1'b0, 32'h0, 32'h0);
    send_word(ACT_FIRST_UNUSED, 1'b0, 32'hffff_ffff, 32'hffff_ffff);
    send_word(ACT_LAST_CODE,  1'b1, 32'h1234_5678, 32'h8765_4321);
    send_word(ACT_INS_AFTER,  1'b0, 32'h1234_5678, 32'h1);
    send_word(ACT_POP_BACK,   1'b0, 32'h0, 32'h0);
    send_word(ACT_POP_FRONT,  1'b0, 32'h0, 32'h0);
    send_word(ACT_REMOVE,     1'b0, 32'h5555_5555, 32'h0);
    drain();

    // random phases cycle fill / mixed / drain bias so full and empty recur
    burst_left = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      kind = ph % 3;
      word_pool[7] = $urandom;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (burst_left == 0) begin
          if ($urandom_range(0, 3) != 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
          end
          burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        send_word(pick_action(kind), 1'($urandom_range(0, 1)), pick_word(), pick_word());
      end
      drain();
    end

    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("ordered_list_engine_test OK");
    else
      $display("ordered_list_engine_test NOT OK");
    $finish;
  end

endmodule
